FILE: src/rtcrf_pkg.sv
`timescale 1ns / 1ps

package rtcrf_pkg;

	// Field widths
	localparam int W_OP     = 2;
	localparam int W_OFFSET = 6;
	localparam int W_BYTE   = 8;
	localparam int W_CYCLES = 16;
	localparam int W_SEC    = 6;
	localparam int W_MIN    = 6;
	localparam int W_HOUR   = 5;
	localparam int W_WDAY   = 3;
	localparam int W_DAY    = 5;
	localparam int W_MON    = 4;
	localparam int W_YEAR   = 12;
	localparam int W_TPS    = 20;
	localparam int W_DIV    = 21;
	localparam int STORE_BYTES = 64;

	localparam logic [W_TPS-1:0] TPS_RESET = 20'd200000;

	// Operation codes
	localparam logic [W_OP-1:0] OP_READ  = 2'd0;
	localparam logic [W_OP-1:0] OP_WRITE = 2'd1;
	localparam logic [W_OP-1:0] OP_TICK  = 2'd2;
	localparam logic [W_OP-1:0] OP_SYNC  = 2'd3;

	// Register offsets
	localparam logic [W_OFFSET-1:0] REG_SEC  = 6'h00;
	localparam logic [W_OFFSET-1:0] REG_MIN  = 6'h02;
	localparam logic [W_OFFSET-1:0] REG_HOUR = 6'h04;
	localparam logic [W_OFFSET-1:0] REG_WDAY = 6'h06;
	localparam logic [W_OFFSET-1:0] REG_DAY  = 6'h07;
	localparam logic [W_OFFSET-1:0] REG_MON  = 6'h08;
	localparam logic [W_OFFSET-1:0] REG_YEAR = 6'h09;
	localparam logic [W_OFFSET-1:0] REG_B    = 6'h0B;
	localparam logic [W_OFFSET-1:0] REG_D    = 6'h0D;

	localparam logic [W_BYTE-1:0] D_VALUE = 8'h80;
	localparam int B_BINARY_BIT = 2;
	localparam int B_SET_BIT    = 7;

	// Sync write sequence, one register per step
	localparam logic [2:0] IDX_SEC  = 3'd0;
	localparam logic [2:0] IDX_MIN  = 3'd1;
	localparam logic [2:0] IDX_HOUR = 3'd2;
	localparam logic [2:0] IDX_WDAY = 3'd3;
	localparam logic [2:0] IDX_DAY  = 3'd4;
	localparam logic [2:0] IDX_MON  = 3'd5;
	localparam logic [2:0] IDX_YEAR = 3'd6;

	// Controller to datapath commands
	typedef struct packed {
		logic       rd_issue;
		logic       wr_issue;
		logic       tick_issue;
		logic       sync_capture;
		logic       sec_adv;
		logic       sec_wr;
		logic       sync_wr;
		logic       load_out;
		logic [2:0] sync_idx;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic adv;
		logic b_set;
	} sts_t;

	// Packed BCD of a value below 100, or its plain binary form
	function automatic logic [7:0] bcd_enc(input logic [6:0] v, input logic bin);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  rem;
		prod = 15'(v) * 15'd205;
		tens = prod[14:11];
		rem  = v - (7'({tens, 3'b000}) + 7'({tens, 1'b0}));
		return bin ? {1'b0, v} : {tens, rem[3:0]};
	endfunction

	// Remainder modulo 60 of a value up to 256
	function automatic logic [5:0] mod60(input logic [8:0] x);
		logic [8:0] r;
		priority if (x >= 9'd240) r = x - 9'd240;
		else if (x >= 9'd180)     r = x - 9'd180;
		else if (x >= 9'd120)     r = x - 9'd120;
		else if (x >= 9'd60)      r = x - 9'd60;
		else                      r = x;
		return r[5:0];
	endfunction

	// Latest year 1972..1999 with given leap status and 1 January weekday,
	// modulo 100
	function automatic logic [6:0] year_lut(input logic leap, input logic [2:0] wd);
		logic [6:0] y;
		unique case ({leap, wd})
			4'b0_000: y = 7'd95;
			4'b0_001: y = 7'd90;
			4'b0_010: y = 7'd91;
			4'b0_011: y = 7'd97;
			4'b0_100: y = 7'd98;
			4'b0_101: y = 7'd99;
			4'b0_110: y = 7'd94;
			4'b1_000: y = 7'd84;
			4'b1_001: y = 7'd96;
			4'b1_010: y = 7'd80;
			4'b1_011: y = 7'd92;
			4'b1_100: y = 7'd76;
			4'b1_101: y = 7'd88;
			4'b1_110: y = 7'd72;
			default:  y = 7'd98;
		endcase
		return y;
	endfunction

endpackage

FILE: src/rtcrf_ctrl.sv
`timescale 1ns / 1ps

module rtcrf_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rtcrf_pkg::W_OP-1:0]    op,
	output logic                          out_valid,
	input  logic                          out_stall,
	input  rtcrf_pkg::sts_t               sts,
	output rtcrf_pkg::cmd_t               cmd
);
	import rtcrf_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_RD      = 5'b00010,
		S_TICK    = 5'b00100,
		S_TICK_WR = 5'b01000,
		S_SYNC    = 5'b10000
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] idx_q, idx_d;
	logic       out_valid_q, out_valid_d;

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		idx_d   = idx_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (op)
						OP_READ: begin
							cmd.rd_issue = 1'b1;
							state_d = S_RD;
						end
						OP_WRITE: begin
							cmd.wr_issue = 1'b1;
						end
						OP_TICK: begin
							cmd.tick_issue = 1'b1;
							state_d = S_TICK;
						end
						OP_SYNC: begin
							if (!sts.b_set) begin
								cmd.sync_capture = 1'b1;
								state_d = S_SYNC;
								idx_d = IDX_SEC;
							end
						end
					endcase
				end
			end
			S_RD: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_TICK: begin
				if (sts.adv) begin
					cmd.sec_adv = 1'b1;
					state_d = S_TICK_WR;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_TICK_WR: begin
				cmd.sec_wr = 1'b1;
				state_d = S_IDLE;
			end
			S_SYNC: begin
				cmd.sync_wr  = 1'b1;
				cmd.sync_idx = idx_q;
				if (idx_q == IDX_YEAR) begin
					state_d = S_IDLE;
				end else begin
					idx_d = idx_q + 3'd1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold a result until taken
	always_comb begin
		out_valid_d = cmd.load_out | (out_valid_q & out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= IDX_SEC;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: src/rtcrf_dp.sv
`timescale 1ns / 1ps

module rtcrf_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rtcrf_pkg::cmd_t                   cmd,
	output rtcrf_pkg::sts_t                   sts,
	input  logic [rtcrf_pkg::W_OFFSET-1:0]    offset,
	input  logic [rtcrf_pkg::W_BYTE-1:0]      write_data,
	input  logic [rtcrf_pkg::W_CYCLES-1:0]    cycles,
	input  logic [rtcrf_pkg::W_SEC-1:0]       host_second,
	input  logic [rtcrf_pkg::W_MIN-1:0]       host_minute,
	input  logic [rtcrf_pkg::W_HOUR-1:0]      host_hour,
	input  logic [rtcrf_pkg::W_WDAY-1:0]      host_weekday,
	input  logic [rtcrf_pkg::W_DAY-1:0]       host_day,
	input  logic [rtcrf_pkg::W_MON-1:0]       host_month,
	input  logic [rtcrf_pkg::W_YEAR-1:0]      host_year,
	input  logic                              cfg_wr_en,
	input  logic [rtcrf_pkg::W_TPS-1:0]       cfg_wr_data,
	output logic [rtcrf_pkg::W_BYTE-1:0]      read_data
);
	import rtcrf_pkg::*;

	// Register store
	logic [W_BYTE-1:0]      mem [STORE_BYTES];
	logic [STORE_BYTES-1:0] valid_q;
	logic [W_BYTE-1:0]      rd_data_q;
	logic                   rd_ok_q;
	logic                   rd_d_q;
	logic [W_BYTE-1:0]      read_data_q;

	// Clock state
	logic [W_TPS-1:0] tps_q;
	logic [W_DIV-1:0] divider_q;
	logic             adv_q;
	logic [7:0]       seconds_q;
	logic [W_BYTE-1:0] b_q;

	// Captured host fields
	logic [W_SEC-1:0]  hsec_q;
	logic [W_MIN-1:0]  hmin_q;
	logic [W_HOUR-1:0] hhour_q;
	logic [W_WDAY-1:0] hwday_q;
	logic [W_DAY-1:0]  hday_q;
	logic [W_MON-1:0]  hmon_q;
	logic [W_YEAR-1:0] hyear_q;

	// Year mapping pipeline
	logic [12:0] p_y;
	logic [24:0] prod_y, prod_p;
	logic [5:0]  q100y_s1, q100p_s1;
	logic [11:0] r100_y;
	logic [12:0] sum_s;
	logic [12:0] s_s2, s_s3;
	logic        leap_s2, leap_s3;
	logic [25:0] prod_7;
	logic [9:0]  q7_s3;
	logic [12:0] r7;
	logic [6:0]  yr_s4;

	// Write port selection
	logic              wr_en;
	logic [W_OFFSET-1:0] wr_addr;
	logic [W_BYTE-1:0] wr_val;
	logic [6:0]        sync_val;
	logic              bin;
	logic [W_DIV-1:0]  div_sum;
	logic              reached;
	logic [7:0]        wr_secs;

	assign bin = b_q[B_BINARY_BIT];

	// Pick the register and value for each sync step
	always_comb begin
		unique case (cmd.sync_idx)
			IDX_SEC:  sync_val = 7'(hsec_q);
			IDX_MIN:  sync_val = 7'(hmin_q);
			IDX_HOUR: sync_val = 7'(hhour_q);
			IDX_WDAY: sync_val = 7'(hwday_q) + 7'd1;
			IDX_DAY:  sync_val = 7'(hday_q);
			IDX_MON:  sync_val = 7'(hmon_q);
			IDX_YEAR: sync_val = yr_s4;
			default:  sync_val = yr_s4;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = REG_SEC;
		wr_val  = write_data;
		priority if (cmd.wr_issue) begin
			wr_en   = (offset != REG_D);
			wr_addr = offset;
			wr_val  = write_data;
		end else if (cmd.sec_wr) begin
			wr_en   = 1'b1;
			wr_addr = REG_SEC;
			wr_val  = bcd_enc(seconds_q[6:0], bin);
		end else if (cmd.sync_wr) begin
			wr_en  = 1'b1;
			wr_val = bcd_enc(sync_val, bin);
			unique case (cmd.sync_idx)
				IDX_SEC:  wr_addr = REG_SEC;
				IDX_MIN:  wr_addr = REG_MIN;
				IDX_HOUR: wr_addr = REG_HOUR;
				IDX_WDAY: wr_addr = REG_WDAY;
				IDX_DAY:  wr_addr = REG_DAY;
				IDX_MON:  wr_addr = REG_MON;
				IDX_YEAR: wr_addr = REG_YEAR;
				default:  wr_addr = REG_YEAR;
			endcase
		end
	end

	// Store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_val;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= mem[offset];
		end
	end

	// Track written entries; an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_ok_q <= 1'b0;
			rd_d_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.rd_issue) begin
				rd_ok_q <= valid_q[offset];
				rd_d_q  <= (offset == REG_D);
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			read_data_q <= rd_d_q ? D_VALUE : (rd_ok_q ? rd_data_q : '0);
		end
	end

	assign read_data = read_data_q;

	// Divider sum and threshold
	assign div_sum = divider_q + W_DIV'(cycles);
	assign reached = (div_sum >= W_DIV'(tps_q));

	// Seconds loaded by a write to register 0
	assign wr_secs = bin ? write_data
		: ({1'b0, write_data[7:4], 3'b000} + {2'b00, write_data[7:4], 1'b0}
			+ {4'b0000, write_data[3:0]});

	// Clock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q     <= TPS_RESET;
			divider_q <= '0;
			adv_q     <= 1'b0;
			seconds_q <= '0;
			b_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				tps_q <= cfg_wr_data;
			end
			if (cmd.tick_issue) begin
				divider_q <= reached ? '0 : div_sum;
				adv_q     <= reached;
			end
			if (cmd.wr_issue && offset == REG_B) begin
				b_q <= write_data;
			end
			priority if (cmd.wr_issue && offset == REG_SEC) begin
				seconds_q <= wr_secs;
			end else if (cmd.sec_adv) begin
				seconds_q <= 8'(mod60(9'(seconds_q) + 9'd1));
			end else if (cmd.sync_capture) begin
				seconds_q <= 8'(host_second);
			end
		end
	end

	// Capture host fields for a sync
	always_ff @(posedge clk) begin
		if (cmd.sync_capture) begin
			hsec_q  <= host_second;
			hmin_q  <= host_minute;
			hhour_q <= host_hour;
			hwday_q <= host_weekday;
			hday_q  <= host_day;
			hmon_q  <= host_month;
			hyear_q <= host_year;
		end
	end

	// Year stage 1: divide year and year-1 (shifted by 400) by 100
	assign p_y    = 13'(hyear_q) + 13'd399;
	assign prod_y = 25'(hyear_q) * 25'd5243;
	assign prod_p = 25'(p_y) * 25'd5243;

	// Year stage 2: leap status and weekday sum
	assign r100_y = hyear_q - 12'(q100y_s1) * 12'd100;
	assign sum_s  = 13'd1 + p_y + 13'(p_y[12:2]) - 13'(q100p_s1) + 13'(q100p_s1[5:2]);

	// Year stage 3: divide by 7; stage 4: remainder and lookup
	assign prod_7 = 26'(s_s2) * 26'd9363;
	assign r7     = s_s3 - 13'(q7_s3) * 13'd7;

	always_ff @(posedge clk) begin
		q100y_s1 <= prod_y[24:19];
		q100p_s1 <= prod_p[24:19];
		s_s2     <= sum_s;
		leap_s2  <= (hyear_q[1:0] == 2'b00) && ((r100_y != '0) || (q100y_s1[1:0] == 2'b00));
		q7_s3    <= prod_7[25:16];
		s_s3     <= s_s2;
		leap_s3  <= leap_s2;
		yr_s4    <= year_lut(leap_s3, r7[2:0]);
	end

	assign sts.adv   = adv_q;
	assign sts.b_set = b_q[B_SET_BIT];

endmodule

FILE: src/rtc_register_file_with_seconds_tick.sv
`timescale 1ns / 1ps
// Read: the store is read into a register as the request is accepted, then
// the result moves to read_data once no earlier result waits on out_stall.
// Write, and a sync while SET is on: handled while idle. Tick: the divider
// updates, then on a rollover the seconds and then register 0 (one store port).
// Sync: one register per cycle through the single store write port.
// Reset (arst_n low) clears control, divider, seconds and store valid bits at
// once, so every register but D reads zero; the threshold returns to 200000.

module rtc_register_file_with_seconds_tick (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rtcrf_pkg::W_OP-1:0]        op,
	input  logic [rtcrf_pkg::W_OFFSET-1:0]    offset,
	input  logic [rtcrf_pkg::W_BYTE-1:0]      write_data,
	input  logic [rtcrf_pkg::W_CYCLES-1:0]    cycles,
	input  logic [rtcrf_pkg::W_SEC-1:0]       host_second,
	input  logic [rtcrf_pkg::W_MIN-1:0]       host_minute,
	input  logic [rtcrf_pkg::W_HOUR-1:0]      host_hour,
	input  logic [rtcrf_pkg::W_WDAY-1:0]      host_weekday,
	input  logic [rtcrf_pkg::W_DAY-1:0]       host_day,
	input  logic [rtcrf_pkg::W_MON-1:0]       host_month,
	input  logic [rtcrf_pkg::W_YEAR-1:0]      host_year,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rtcrf_pkg::W_BYTE-1:0]      read_data,
	input  logic                              cfg_wr_en,
	input  logic [rtcrf_pkg::W_TPS-1:0]       cfg_wr_data
);
	import rtcrf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rtcrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rtcrf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.offset       (offset),
		.write_data   (write_data),
		.cycles       (cycles),
		.host_second  (host_second),
		.host_minute  (host_minute),
		.host_hour    (host_hour),
		.host_weekday (host_weekday),
		.host_day     (host_day),
		.host_month   (host_month),
		.host_year    (host_year),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.read_data    (read_data)
	);

	// Never overwrite a result still waiting at the output
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || !out_stall))
		else $error("read result overwritten while pending");

	// One source on the store write port
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_issue, cmd.sec_wr, cmd.sync_wr}))
		else $error("store write port claimed twice");

	// A sync is started only while SET is clear
	a_sync_gate: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sync_capture |-> !sts.b_set)
		else $error("sync started while SET is on");

	// An accepted read blocks the input until its result is loaded
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && op == OP_READ) |=> in_stall)
		else $error("input taken during read");

endmodule
